// ===== hdl/iss_pkg.sv =====
// Package for the indexed stack with sort: sizes, request and status codes,
// and the sequencer state type. No dependencies; the interfaces, top level, checker and bench use it.
package iss_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;

  localparam int AddrW  = $clog2(DEPTH);
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int ValueW = 32;
  localparam int PosW   = 9;
  localparam int CountW = 9;
  localparam int CmpW   = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_WRITE = 3'd4,
    ACT_TRUNC = 3'd5,
    ACT_CLEAR = 3'd6,
    ACT_SORT  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RESP,
    FSM_LOAD,
    FSM_CUR,
    FSM_CMP,
    FSM_PLACE
  } fsm_t;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CntW-1:0]       cnt_t;

endpackage

// ===== hdl/iss_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on iss_pkg for the payload types.
interface iss_req_if;
  logic                       valid;
  logic                       ready;
  iss_pkg::action_t           action;
  logic signed [iss_pkg::ValueW-1:0] value;
  logic [iss_pkg::PosW-1:0]   position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface iss_rsp_if;
  logic                       valid;
  logic                       ready;
  logic signed [iss_pkg::ValueW-1:0] data;
  iss_pkg::status_t           status;
  logic [iss_pkg::CountW-1:0] count;

  modport source (output valid, data, status, count, input ready);
  modport sink   (input valid, data, status, count, output ready);
endinterface

// ===== hdl/iss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/indexed_stack_with_sort.sv =====
// Top level of the indexed stack with sort: request decode, fill counter,
// insertion-sort sequencer and response register. Uses iss_pkg, iss_if, iss_ram.
//
//   Channel  Direction  Beat contents                       Handshake
//   in_ch    sink       action, value, position             valid/ready
//   out_ch   source     data, status, count                 valid/ready
//
// Push, write, truncate, clear and every rejected request are answered straight
// from idle; pop, peek and read pass through the response state, since the
// entry RAM has one registered read port. A sort loads each entry in turn, reads
// the one below it and compares down the stack, shifting larger ones up.
// Reset clears the fill count and the control state; the entries stay as they
// are and are never read above the fill count. A stalled response holds the
// request side off until the response register drains.
module indexed_stack_with_sort (
  input  logic clk,
  input  logic rst_n,
  iss_req_if.sink   in_ch,
  iss_rsp_if.source out_ch
);

  import iss_pkg::*;

  // Sequencer and stack state.
  fsm_t  state_r, state_nxt;
  cnt_t  fill_r,  fill_nxt;
  cnt_t  i_r,     i_nxt;     // insertion sort: index of the entry being placed
  cnt_t  j_r,     j_nxt;     // insertion sort: hole that the entry may drop into
  word_t cur_r,   cur_nxt;   // insertion sort: the entry being placed

  // Response register.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [ValueW-1:0] out_data_r;
  status_t                  out_status_r;
  logic [CountW-1:0]        out_count_r;

  logic                     rsp_load;
  logic signed [ValueW-1:0] rsp_data;
  status_t                  rsp_status;

  // Entry RAM port.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  word_t            ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  word_t            ram_rdata;

  // Request decode.
  logic             in_fire;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  fill_ext;
  logic             pos_bad;
  logic [AddrW-1:0] pos_addr;
  logic [AddrW-1:0] top_addr;
  word_t            in_word;
  cnt_t             i_inc;
  logic             sort_more;
  logic             shift_up;

  iss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A new request is taken only in idle and only when the response register
  // is free or is handing its beat over in this cycle.
  assign in_ch.ready = (state_r == FSM_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign pos_ext  = CmpW'(in_ch.position);
  assign fill_ext = CmpW'(fill_r);
  assign pos_bad  = (pos_ext == '0) || (pos_ext > fill_ext);
  assign pos_addr = AddrW'(pos_ext - CmpW'(1));
  assign top_addr = AddrW'(fill_r - cnt_t'(1));
  assign in_word  = DATA_WIDTH'($unsigned(in_ch.value));

  assign i_inc     = i_r + cnt_t'(1);
  assign sort_more = (i_inc < fill_r);
  // The entry just read below the hole is larger than the one being placed,
  // so it moves up by one and the hole moves down.
  assign shift_up  = ($signed(ram_rdata) > $signed(cur_r));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          case (in_ch.action)
            ACT_POP, ACT_PEEK: begin
              if (fill_r != '0) state_nxt = FSM_RESP;
            end
            ACT_READ: begin
              if (!pos_bad) state_nxt = FSM_RESP;
            end
            ACT_SORT: begin
              if (fill_r > cnt_t'(1)) state_nxt = FSM_LOAD;
            end
            default: state_nxt = FSM_IDLE;
          endcase
        end
      end
      FSM_RESP:  state_nxt = FSM_IDLE;
      FSM_LOAD:  state_nxt = FSM_CUR;
      FSM_CUR:   state_nxt = FSM_CMP;
      FSM_CMP: begin
        if (shift_up) begin
          state_nxt = (j_r == cnt_t'(1)) ? FSM_PLACE : FSM_CMP;
        end else begin
          state_nxt = sort_more ? FSM_LOAD : FSM_IDLE;
        end
      end
      FSM_PLACE: state_nxt = sort_more ? FSM_LOAD : FSM_IDLE;
      default:   state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath and RAM control for each state.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = fill_r[AddrW-1:0];
    ram_wdata  = in_word;
    ram_raddr  = top_addr;
    fill_nxt   = fill_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cur_nxt    = cur_r;
    rsp_load   = 1'b0;
    rsp_data   = '0;
    rsp_status = STAT_OK;

    case (state_r)
      FSM_IDLE: begin
        // The read for pop, peek and read goes out at the accepting edge.
        if (in_ch.action == ACT_READ) begin
          ram_raddr = pos_addr;
        end
        if (in_fire) begin
          case (in_ch.action)
            ACT_PUSH: begin
              rsp_load = 1'b1;
              if (fill_r == cnt_t'(DEPTH)) begin
                rsp_status = STAT_FULL;
              end else begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + cnt_t'(1);
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (fill_r == '0) begin
                rsp_load   = 1'b1;
                rsp_status = STAT_EMPTY;
              end else if (in_ch.action == ACT_POP) begin
                fill_nxt = fill_r - cnt_t'(1);
              end
            end
            ACT_READ: begin
              if (pos_bad) begin
                rsp_load   = 1'b1;
                rsp_status = STAT_BADPOS;
              end
            end
            ACT_WRITE: begin
              rsp_load = 1'b1;
              if (pos_bad) begin
                rsp_status = STAT_BADPOS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_addr;
              end
            end
            ACT_TRUNC: begin
              rsp_load = 1'b1;
              if (pos_ext > fill_ext) begin
                rsp_status = STAT_BADPOS;
              end else begin
                fill_nxt = cnt_t'(pos_ext);
              end
            end
            ACT_CLEAR: begin
              rsp_load = 1'b1;
              fill_nxt = '0;
            end
            ACT_SORT: begin
              // Zero or one entry is already in order.
              if (fill_r > cnt_t'(1)) begin
                i_nxt = cnt_t'(1);
              end else begin
                rsp_load = 1'b1;
              end
            end
            default: rsp_load = 1'b0;
          endcase
        end
      end
      FSM_RESP: begin
        rsp_load = 1'b1;
        rsp_data = ValueW'($signed(ram_rdata));
      end
      FSM_LOAD: begin
        ram_raddr = i_r[AddrW-1:0];
      end
      FSM_CUR: begin
        cur_nxt   = ram_rdata;
        j_nxt     = i_r;
        ram_raddr = AddrW'(i_r - cnt_t'(1));
      end
      FSM_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AddrW-1:0];
        ram_raddr = AddrW'(j_r - cnt_t'(2));
        if (shift_up) begin
          ram_wdata = ram_rdata;
          j_nxt     = j_r - cnt_t'(1);
        end else begin
          ram_wdata = cur_r;
          i_nxt     = i_inc;
          rsp_load  = !sort_more;
        end
      end
      FSM_PLACE: begin
        // The entry being placed is the smallest so far: it lands at the bottom.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = cur_r;
        i_nxt     = i_inc;
        rsp_load  = !sort_more;
      end
      default: rsp_load = 1'b0;
    endcase
  end

  assign out_valid_nxt = rsp_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cur_r <= cur_nxt;
    if (rsp_load) begin
      out_data_r   <= rsp_data;
      out_status_r <= rsp_status;
      out_count_r  <= CountW'(fill_nxt);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.status = out_status_r;
  assign out_ch.count  = out_count_r;

endmodule

// ===== hdl/iss_checker.sv =====
// Port-level checks for the indexed stack with sort, and the bind that
// attaches them to the top level. Uses iss_pkg.
module iss_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [iss_pkg::ValueW-1:0] out_data,
  input iss_pkg::status_t                  out_status,
  input logic [iss_pkg::CountW-1:0]        out_count
);

  import iss_pkg::*;

  // A stalled response beat holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) &&
      $stable(out_status) && $stable(out_count))
    else $error("response beat changed while stalled");

  // An empty report means the stack really is empty.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  // A full report means the stack holds its whole depth.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> (out_count == CountW'(DEPTH)))
    else $error("full status with count below depth");

  // A failed request returns no data.
  a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_data == '0))
    else $error("failed request returned data");

endmodule

bind indexed_stack_with_sort iss_checker u_iss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data),
  .out_status (out_ch.status),
  .out_count  (out_ch.count)
);

// ===== dv/tb.sv =====
// Self-checking bench for indexed_stack_with_sort: random requests against an
// in-bench stack mirror, with random idling on both channels.
// Depends on iss_pkg, iss_req_if, iss_rsp_if and the indexed_stack_with_sort RTL.
module tb;
  import iss_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] sword_t;

  typedef struct {
    action_t           action;
    sword_t            value;
    logic [PosW-1:0]   position;
  } request_t;

  typedef struct {
    sword_t            data;
    status_t           status;
    logic [CountW-1:0] count;
  } response_t;

  typedef enum {EP_GROW, EP_SHRINK, EP_ACCESS, EP_NOISE} episode_t;

  // Number of random requests to generate, and the beat window (on each side)
  // in which neither channel idles.
  localparam int unsigned NumRequests = 1600;
  localparam int unsigned CalmFrom    = 700;
  localparam int unsigned CalmTo      = 950;
  // Sorting is cheap only on a short stack; random sorts are kept below this.
  localparam int unsigned SortMax     = 48;

  logic clk;
  logic rst_n;

  iss_req_if in_ch();
  iss_rsp_if out_ch();

  indexed_stack_with_sort i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests waiting to be driven, and responses predicted but not yet seen.
  request_t    pending_requests[$];
  response_t   awaited_responses[$];

  // Mirror of the stack contents and fill level, advanced on every accepted beat.
  sword_t      mirror_entries[DEPTH];
  int unsigned mirror_fill;

  // Fill level as the generator expects it; it only steers position choices.
  int unsigned gen_fill;

  int unsigned total_requests;
  int unsigned beats_accepted;
  int unsigned responses_seen;
  int unsigned mismatches;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // All block inputs are known from time zero, and reset is asserted from time zero.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_PUSH;
    in_ch.value      = '0;
    in_ch.position   = '0;
    out_ch.ready     = 1'b0;
    mirror_fill      = 0;
    beats_accepted   = 0;
    responses_seen   = 0;
    mismatches       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Applies one request to the mirror and returns the response it must produce.
  function automatic response_t stack_apply(request_t req);
    response_t rsp;
    sword_t    cur;
    int        i;
    int        j;
    rsp.data   = '0;
    rsp.status = STAT_OK;
    case (req.action)
      ACT_PUSH: begin
        if (mirror_fill >= DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          mirror_entries[mirror_fill] = req.value;
          mirror_fill++;
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (mirror_fill == 0) begin
          rsp.status = STAT_EMPTY;
        end else begin
          rsp.data = mirror_entries[mirror_fill - 1];
          if (req.action == ACT_POP) mirror_fill--;
        end
      end
      ACT_READ, ACT_WRITE: begin
        if (req.position == 0 || req.position > mirror_fill) begin
          rsp.status = STAT_BADPOS;
        end else if (req.action == ACT_READ) begin
          rsp.data = mirror_entries[req.position - 1];
        end else begin
          mirror_entries[req.position - 1] = req.value;
        end
      end
      ACT_TRUNC: begin
        if (req.position > mirror_fill) begin
          rsp.status = STAT_BADPOS;
        end else begin
          mirror_fill = req.position;
        end
      end
      ACT_CLEAR: begin
        mirror_fill = 0;
      end
      default: begin
        // Ascending signed order from the bottom; only live entries move.
        for (i = 1; i < int'(mirror_fill); i++) begin
          cur = mirror_entries[i];
          j   = i;
          while (j > 0 && mirror_entries[j - 1] > cur) begin
            mirror_entries[j] = mirror_entries[j - 1];
            j--;
          end
          mirror_entries[j] = cur;
        end
      end
    endcase
    rsp.count = CountW'(mirror_fill);
    return rsp;
  endfunction

  // Queues a request and tracks the fill level it will leave behind.
  task automatic add_request(input action_t act, input sword_t val, input int unsigned pos);
    request_t req;
    req.action   = act;
    req.value    = val;
    req.position = PosW'(pos);
    pending_requests.push_back(req);
    case (act)
      ACT_PUSH:  if (gen_fill < DEPTH) gen_fill++;
      ACT_POP:   if (gen_fill > 0) gen_fill--;
      ACT_TRUNC: if (req.position <= gen_fill) gen_fill = req.position;
      ACT_CLEAR: gen_fill = 0;
      default: ;
    endcase
  endtask

  // Values lean toward the signed extremes and a narrow band around zero, so
  // that sorts see both extremes and plenty of equal keys.
  function automatic sword_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 4))
        0:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        1:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        2:       return '0;
        3:       return '1;
        default: return sword_t'(1);
      endcase
    end else if (roll < 35) begin
      return sword_t'($urandom_range(0, 16)) - 8;
    end
    return sword_t'($urandom);
  endfunction

  function automatic int unsigned good_position();
    if (gen_fill == 0) return 0;
    return $urandom_range(1, gen_fill);
  endfunction

  // A rejected position: zero, or anything above the fill up to the field's top.
  function automatic int unsigned bad_position();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(gen_fill + 1, (1 << PosW) - 1);
  endfunction

  task automatic random_request(input episode_t kind);
    int unsigned roll;
    int unsigned pos;
    action_t     act;
    roll = $urandom_range(0, 99);
    case (kind)
      EP_GROW: begin
        act = (roll < 65) ? ACT_PUSH : (roll < 75) ? ACT_WRITE :
              (roll < 85) ? ACT_READ : (roll < 92) ? ACT_PEEK : ACT_POP;
      end
      EP_SHRINK: begin
        act = (roll < 45) ? ACT_POP : (roll < 55) ? ACT_TRUNC :
              (roll < 65) ? ACT_PEEK : (roll < 80) ? ACT_READ :
              (roll < 90) ? ACT_WRITE : (roll < 93) ? ACT_CLEAR : ACT_PUSH;
      end
      EP_ACCESS: begin
        act = (roll < 30) ? ACT_READ : (roll < 60) ? ACT_WRITE :
              (roll < 70) ? ACT_PEEK : (roll < 80) ? ACT_PUSH :
              (roll < 90) ? ACT_POP : (roll < 96) ? ACT_SORT : ACT_TRUNC;
      end
      default: begin
        act = action_t'($urandom_range(0, 7));
      end
    endcase
    // A sort of a tall stack is slow; such sorts are left to the dedicated
    // full-stack sequence.
    if (act == ACT_SORT && gen_fill > SortMax) act = ACT_PEEK;
    if (kind == EP_NOISE) begin
      pos = $urandom_range(0, (1 << PosW) - 1);
    end else if (act == ACT_TRUNC) begin
      pos = ($urandom_range(0, 99) < 85) ? $urandom_range(0, gen_fill) : bad_position();
    end else begin
      pos = ($urandom_range(0, 99) < 90) ? good_position() : bad_position();
    end
    add_request(act, pick_value(), pos);
  endtask

  // Pushes up to the top, pushes past it, works the topmost positions, sorts
  // the whole store and then cuts the stack back to a short one.
  task automatic fill_to_top();
    while (gen_fill < DEPTH) add_request(ACT_PUSH, pick_value(), $urandom_range(0, 511));
    repeat (3) add_request(ACT_PUSH, pick_value(), 0);
    add_request(ACT_PEEK,  pick_value(), 0);
    add_request(ACT_READ,  pick_value(), DEPTH);
    add_request(ACT_WRITE, pick_value(), DEPTH);
    add_request(ACT_READ,  pick_value(), DEPTH + 1);
    add_request(ACT_WRITE, pick_value(), DEPTH + 1);
    add_request(ACT_TRUNC, pick_value(), DEPTH + 1);
    add_request(ACT_TRUNC, pick_value(), DEPTH);
    add_request(ACT_SORT,  pick_value(), 0);
    add_request(ACT_READ,  pick_value(), 1);
    add_request(ACT_READ,  pick_value(), DEPTH);
    add_request(ACT_POP,   pick_value(), 0);
    add_request(ACT_TRUNC, pick_value(), $urandom_range(0, 24));
  endtask

  // Idle decision shared by both channels; progress is that side's beat count.
  function automatic bit skip_cycle(int unsigned progress);
    if (progress >= CalmFrom && progress < CalmTo) return 1'b0;
    return $urandom_range(0, 99) < 35;
  endfunction

  // Stimulus, then the wait for the last response and the verdict.
  initial begin : stimulus
    episode_t    kind;
    int unsigned roll;
    int unsigned full_runs;
    gen_fill  = 0;
    full_runs = 0;

    // Directed opening: every rejection on an empty stack, the signed
    // extremes, every action, and positions at zero and past the fill.
    add_request(ACT_POP,   pick_value(), 0);
    add_request(ACT_PEEK,  pick_value(), 0);
    add_request(ACT_READ,  pick_value(), 0);
    add_request(ACT_READ,  pick_value(), 1);
    add_request(ACT_WRITE, pick_value(), 1);
    add_request(ACT_TRUNC, pick_value(), 0);
    add_request(ACT_TRUNC, pick_value(), 1);
    add_request(ACT_SORT,  pick_value(), 0);
    add_request(ACT_PUSH,  {1'b0, {(DATA_WIDTH-1){1'b1}}}, 0);
    add_request(ACT_PUSH,  {1'b1, {(DATA_WIDTH-1){1'b0}}}, 0);
    add_request(ACT_PUSH,  '0, 0);
    add_request(ACT_PUSH,  '1, 0);
    add_request(ACT_PUSH,  sword_t'(1), 0);
    add_request(ACT_PEEK,  pick_value(), 0);
    add_request(ACT_WRITE, pick_value(), 0);
    add_request(ACT_READ,  pick_value(), 5);
    add_request(ACT_READ,  pick_value(), 6);
    add_request(ACT_WRITE, sword_t'(5), 1);
    add_request(ACT_READ,  pick_value(), 1);
    add_request(ACT_SORT,  pick_value(), 0);
    add_request(ACT_READ,  pick_value(), 1);
    add_request(ACT_POP,   pick_value(), 0);
    add_request(ACT_TRUNC, pick_value(), 2);
    add_request(ACT_READ,  pick_value(), 511);
    add_request(ACT_CLEAR, pick_value(), 0);

    // Random episodes of one flavor each, with two full-stack sequences.
    while (pending_requests.size() < NumRequests) begin
      if ((full_runs == 0 && pending_requests.size() > 300) ||
          (full_runs == 1 && pending_requests.size() > 1000)) begin
        fill_to_top();
        full_runs++;
      end else begin
        roll = $urandom_range(0, 99);
        kind = (roll < 25) ? EP_GROW : (roll < 55) ? EP_SHRINK :
               (roll < 85) ? EP_ACCESS : EP_NOISE;
        repeat ($urandom_range(20, 60)) random_request(kind);
      end
    end
    total_requests = pending_requests.size();

    while (beats_accepted < total_requests) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    // Every request yields a response, so a short drain exposes stray beats.
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("indexed_stack_with_sort regression: pass");
    end else begin
      $display("indexed_stack_with_sort regression: fail");
    end
    $finish;
  end

  // Request driver. A new beat is presented only once the previous one has
  // been taken; the accepted beat is run through the mirror on the same edge.
  always @(posedge clk) begin : driver
    request_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        req.action   = in_ch.action;
        req.value    = in_ch.value;
        req.position = in_ch.position;
        awaited_responses.push_back(stack_apply(req));
        beats_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 && !skip_cycle(beats_accepted)) begin
          req = pending_requests.pop_front();
          in_ch.action   <= req.action;
          in_ch.value    <= req.value;
          in_ch.position <= req.position;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid    <= 1'b0;
        end
      end
    end
  end

  // Response monitor. It stalls the block at random and compares each beat
  // with the oldest prediction, field by field.
  always @(posedge clk) begin : monitor
    response_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          $error("response beat with none outstanding: data %0d, status %0d, count %0d",
                 out_ch.data, out_ch.status, out_ch.count);
        end else begin
          want = awaited_responses.pop_front();
          if (out_ch.data !== want.data) begin
            mismatches++;
            $error("data: expected %0d, got %0d", want.data, out_ch.data);
          end
          if (out_ch.status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
          end
          if (out_ch.count !== want.count) begin
            mismatches++;
            $error("count: expected %0d, got %0d", want.count, out_ch.count);
          end
        end
        responses_seen++;
      end
      out_ch.ready <= !skip_cycle(responses_seen);
    end
  end

  // Watchdog, several times the slowest legal run including two full sorts.
  initial begin
    #2000000;
    $display("indexed_stack_with_sort regression: fail");
    $finish;
  end

endmodule
